// ===== rtl/tha_pkg.sv =====
package tha_pkg;

  // Field widths of one request and one result.
  localparam int SideW  = 16;
  localparam int PerimW = 17;
  localparam int AreaW  = 21;

  // Heron factors: perimeter and the three shifted sums.
  localparam int FacW = 16;
  localparam int PxW  = PerimW + FacW;   // perimeter times first factor
  localparam int YzW  = 2 * FacW;        // product of the other two factors
  localparam int HalfW = YzW / 2;
  localparam int PartW = PxW + HalfW;    // one partial product
  localparam int ProdW = 62;             // full product stays below 2^62

  // The area is isqrt(prod) >> 10, which equals isqrt(prod >> 20).
  localparam int DropW     = 20;
  localparam int RadW      = ProdW - DropW;
  localparam int SqrtSteps = AreaW;

  // Stream widths.
  localparam int InDataW  = 3 * SideW;
  localparam int OutDataW = ((PerimW + AreaW + 7) / 8) * 8;

  // Sideband that travels with every pipeline stage.
  typedef struct packed {
    logic              vld;
    logic              ok;
    logic [PerimW-1:0] perim;
  } side_t;

endpackage

// ===== rtl/triangle_heron_area.sv =====
// Heron triangle area over a stream. Each request carries three signed Q8.8
// side lengths; each result gives a valid flag, the perimeter as unsigned
// Q9.8 and the area as unsigned Q13.8, truncated. A triangle is valid when
// no side is negative and every pair of sides sums to strictly more than the
// third; an invalid one returns the flag low with perimeter and area zero.
// One request is taken per clock while the output is not stalled. One stage
// forms the side sums, three stages form the exact 62-bit Heron product with
// 17x16, 16x16 and then 33x16 multipliers, 21 stages run the bit-per-stage
// square root and one output register holds the result. The whole pipeline
// holds while the output is stalled, so nothing is lost or repeated.
module triangle_heron_area (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // side_one [15:0], side_two [31:16], side_three [47:32]
  input  logic [tha_pkg::InDataW-1:0]      s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // perimeter [16:0], area [37:17], zero fill above
  output logic [tha_pkg::OutDataW-1:0]     m_axis_tdata,
  // valid_res [0]
  output logic                             m_axis_tuser
);
  import tha_pkg::*;

  logic              en;
  side_t             prep_side, mult_side, sqrt_side;
  logic [PerimW-1:0] fac_p;
  logic [FacW-1:0]   fac_x, fac_y, fac_z;
  logic [RadW-1:0]   rad;
  logic [AreaW-1:0]  root;
  logic              out_vld_q;
  logic              out_ok_q;
  logic [OutDataW-1:0] out_data_q;

  // The pipeline advances whenever the output register is free or being taken.
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  tha_prep u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .vld_i        (s_axis_tvalid),
    .side_one_i   (s_axis_tdata[SideW-1:0]),
    .side_two_i   (s_axis_tdata[2*SideW-1:SideW]),
    .side_three_i (s_axis_tdata[3*SideW-1:2*SideW]),
    .side_o       (prep_side),
    .fac_p_o      (fac_p),
    .fac_x_o      (fac_x),
    .fac_y_o      (fac_y),
    .fac_z_o      (fac_z)
  );

  tha_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .side_i  (prep_side),
    .fac_p_i (fac_p),
    .fac_x_i (fac_x),
    .fac_y_i (fac_y),
    .fac_z_i (fac_z),
    .side_o  (mult_side),
    .rad_o   (rad)
  );

  tha_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (mult_side),
    .rad_i  (rad),
    .side_o (sqrt_side),
    .root_o (root)
  );

  // Output register valid and flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      out_ok_q  <= 1'b0;
    end else if (en) begin
      out_vld_q <= sqrt_side.vld;
      out_ok_q  <= sqrt_side.ok;
    end
  end

  // Output payload; perimeter is already zero for an invalid triangle.
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= OutDataW'({root, sqrt_side.perim});
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ok_q;

endmodule

// ===== rtl/tha_prep.sv =====
module tha_prep (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  logic signed [tha_pkg::SideW-1:0]  side_one_i,
  input  logic signed [tha_pkg::SideW-1:0]  side_two_i,
  input  logic signed [tha_pkg::SideW-1:0]  side_three_i,
  output tha_pkg::side_t                    side_o,
  output logic [tha_pkg::PerimW-1:0]        fac_p_o,
  output logic [tha_pkg::FacW-1:0]          fac_x_o,
  output logic [tha_pkg::FacW-1:0]          fac_y_o,
  output logic [tha_pkg::FacW-1:0]          fac_z_o
);
  import tha_pkg::*;

  localparam int SumW = SideW + 2;

  logic signed [SumW-1:0] a, b, c, sab, sbc, sac, sabc;
  logic                   ok;
  side_t                  side_d, side_q;
  logic [PerimW-1:0]      p_d, p_q;
  logic [FacW-1:0]        x_d, y_d, z_d, x_q, y_q, z_q;

  // Pair sums and the validity check on the widened signed sides.
  always_comb begin
    a    = SumW'(side_one_i);
    b    = SumW'(side_two_i);
    c    = SumW'(side_three_i);
    sab  = a + b;
    sbc  = b + c;
    sac  = a + c;
    sabc = sab + c;
    ok   = !side_one_i[SideW-1] && !side_two_i[SideW-1] && !side_three_i[SideW-1] &&
           (sab > c) && (sbc > a) && (sac > b);
  end

  // Factors are zeroed for an invalid triangle so the product and area come out zero.
  always_comb begin
    side_d.vld   = vld_i;
    side_d.ok    = ok;
    p_d          = ok ? sabc[PerimW-1:0] : '0;
    side_d.perim = p_d;
    x_d          = ok ? FacW'(sbc - a) : '0;
    y_d          = ok ? FacW'(sac - b) : '0;
    z_d          = ok ? FacW'(sab - c) : '0;
  end

  // Stage sideband with the valid bit, flag and perimeter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_d;
    end
  end

  // Factor registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign side_o  = side_q;
  assign fac_p_o = p_q;
  assign fac_x_o = x_q;
  assign fac_y_o = y_q;
  assign fac_z_o = z_q;

endmodule

// ===== rtl/tha_mult.sv =====
module tha_mult (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  tha_pkg::side_t              side_i,
  input  logic [tha_pkg::PerimW-1:0]  fac_p_i,
  input  logic [tha_pkg::FacW-1:0]    fac_x_i,
  input  logic [tha_pkg::FacW-1:0]    fac_y_i,
  input  logic [tha_pkg::FacW-1:0]    fac_z_i,
  output tha_pkg::side_t              side_o,
  output logic [tha_pkg::RadW-1:0]    rad_o
);
  import tha_pkg::*;

  side_t             side_q [3];
  logic [PxW-1:0]    px_q;
  logic [YzW-1:0]    yz_q;
  logic [PartW-1:0]  lo_q, hi_q;
  logic [ProdW-1:0]  sum;
  logic [RadW-1:0]   rad_q;

  // Sideband follows the three multiply stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q[0] <= '0;
      side_q[1] <= '0;
      side_q[2] <= '0;
    end else if (en_i) begin
      side_q[0] <= side_i;
      side_q[1] <= side_q[0];
      side_q[2] <= side_q[1];
    end
  end

  // Recombine the two partial products; only the bits above the dropped ones are kept.
  assign sum = ProdW'({hi_q, HalfW'(0)}) + ProdW'(lo_q);

  // First stage pairs the factors, second multiplies the first pair's product by each
  // half of the second's, third adds the partial products and drops the low bits.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q  <= PxW'(fac_p_i) * PxW'(fac_x_i);
      yz_q  <= YzW'(fac_y_i) * YzW'(fac_z_i);
      lo_q  <= PartW'(px_q) * PartW'(yz_q[HalfW-1:0]);
      hi_q  <= PartW'(px_q) * PartW'(yz_q[YzW-1:HalfW]);
      rad_q <= sum[ProdW-1:DropW];
    end
  end

  assign side_o = side_q[2];
  assign rad_o  = rad_q;

endmodule

// ===== rtl/tha_sqrt.sv =====
module tha_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  tha_pkg::side_t              side_i,
  input  logic [tha_pkg::RadW-1:0]    rad_i,
  output tha_pkg::side_t              side_o,
  output logic [tha_pkg::AreaW-1:0]   root_o
);
  import tha_pkg::*;

  side_t           side_q [SqrtSteps];
  logic [RadW-1:0] rem_q  [SqrtSteps];
  logic [RadW-1:0] root_q [SqrtSteps];

  // One result bit per stage, most significant first.
  for (genvar j = 0; j < SqrtSteps; j++) begin : g_step
    localparam int K = SqrtSteps - 1 - j;
    localparam logic [RadW-1:0] StepBit = RadW'(1) << (2 * K);

    side_t           side_in;
    logic [RadW-1:0] rem_in, root_in, trial;
    logic            take;

    if (j == 0) begin : g_first
      assign side_in = side_i;
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign side_in = side_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    // Subtract the trial value when it fits under the remainder.
    assign trial = root_in + StepBit;
    assign take  = rem_in >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[j] <= '0;
      end else if (en_i) begin
        side_q[j] <= side_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= take ? rem_in - trial : rem_in;
        root_q[j] <= take ? (root_in >> 1) + StepBit : root_in >> 1;
      end
    end
  end

  assign side_o = side_q[SqrtSteps-1];
  assign root_o = root_q[SqrtSteps-1][AreaW-1:0];

endmodule

// ===== tb/triangle_heron_area_test.sv =====
module triangle_heron_area_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tha_pkg::*;

  localparam int CycleLimit = 100000;
  localparam int SettleCycles = 40;
  localparam int SideMax = 32767;

  // Expected result of one triangle request.
  typedef struct packed {
    logic              ok;
    logic [PerimW-1:0] perim;
    logic [AreaW-1:0]  area;
  } heron_res_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // side_one [15:0], side_two [31:16], side_three [47:32]
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // perimeter [16:0], area [37:17], zero fill above
  logic [OutDataW-1:0] m_axis_tdata;
  // valid_res [0]
  logic                m_axis_tuser;

  heron_res_t pending_areas[$];
  bit         gaps_on = 1'b1;
  int         hold_req = 0;
  int         hold_left = 0;
  int         cycles = 0;
  int         errors = 0;
  int         n_sent = 0;
  int         n_checked = 0;
  int         n_good = 0;

  triangle_heron_area u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Run limit in case the stream locks up.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, pending_areas.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Validity check, perimeter and exact Heron area with a truncating square root.
  function automatic heron_res_t heron_predict(logic signed [SideW-1:0] a,
                                               logic signed [SideW-1:0] b,
                                               logic signed [SideW-1:0] c);
    int         sa;
    int         sb;
    int         sc;
    bit [63:0]  p;
    bit [63:0]  prod;
    bit [63:0]  root;
    bit [63:0]  probe;
    heron_res_t r;
    r = '0;
    sa = a;
    sb = b;
    sc = c;
    if (sa >= 0 && sb >= 0 && sc >= 0 &&
        sa + sb > sc && sb + sc > sa && sa + sc > sb) begin
      p = 64'(sa + sb + sc);
      prod = p * 64'(sb + sc - sa) * 64'(sa + sc - sb) * 64'(sa + sb - sc);
      root = '0;
      probe = 64'd1 << 62;
      while (probe > prod) probe >>= 2;
      while (probe != 0) begin
        if (prod >= root + probe) begin
          prod -= root + probe;
          root = (root >> 1) + probe;
        end else begin
          root >>= 1;
        end
        probe >>= 2;
      end
      r.ok = 1'b1;
      r.perim = p[PerimW-1:0];
      r.area = AreaW'(root >> 10);
    end
    return r;
  endfunction

  // Offer one triangle, with random idle cycles ahead of it when gaps_on is set,
  // and record the expected result once taken. Starts and ends at a falling edge.
  task automatic send_triangle(logic signed [SideW-1:0] a,
                               logic signed [SideW-1:0] b,
                               logic signed [SideW-1:0] c);
    while (gaps_on && $urandom_range(99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {c, b, a};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_areas.push_back(heron_predict(a, b, c));
    n_sent++;
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every outstanding result has come back.
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_areas.size() != 0);
  endtask

  // Random sides: mostly real triangles, some on the degenerate edge, some raw.
  task automatic make_triangle(output logic signed [SideW-1:0] a,
                               output logic signed [SideW-1:0] b,
                               output logic signed [SideW-1:0] c);
    int kind;
    int span;
    int x;
    int y;
    int z;
    int lo_c;
    int hi_c;
    int t;
    kind = $urandom_range(99);
    case ($urandom_range(3))
      0:       span = 63;
      1:       span = 4095;
      default: span = SideMax;
    endcase
    if (kind < 70) begin
      x = $urandom_range(span, 1);
      y = $urandom_range(span, 1);
      lo_c = (x > y ? x - y : y - x) + 1;
      hi_c = x + y - 1;
      if (hi_c > SideMax) hi_c = SideMax;
      z = $urandom_range(hi_c, lo_c);
    end else if (kind < 85) begin
      x = $urandom_range(span);
      y = $urandom_range(span);
      case ($urandom_range(2))
        0:       z = x + y;
        1:       z = x > y ? x - y : y - x;
        default: z = x + y - 1;
      endcase
      if (z > SideMax || z < 0) z = x > y ? x - y : y - x;
    end else begin
      x = $urandom_range(65535);
      y = $urandom_range(65535);
      z = $urandom_range(65535);
    end
    if ($urandom_range(1) == 1) begin
      t = x;
      x = y;
      y = t;
    end
    case ($urandom_range(2))
      0: begin
        a = SideW'(x);
        b = SideW'(y);
        c = SideW'(z);
      end
      1: begin
        a = SideW'(z);
        b = SideW'(x);
        c = SideW'(y);
      end
      default: begin
        a = SideW'(y);
        b = SideW'(z);
        c = SideW'(x);
      end
    endcase
  endtask

  task automatic send_random(int count);
    logic signed [SideW-1:0] a;
    logic signed [SideW-1:0] b;
    logic signed [SideW-1:0] c;
    repeat (count) begin
      make_triangle(a, b, c);
      send_triangle(a, b, c);
    end
  endtask

  // Field extremes, rejected sides, degenerate and barely valid triangles.
  task automatic test_directed();
    send_triangle(16'sd32767, 16'sd32767, 16'sd32767);
    send_triangle(16'sd1, 16'sd1, 16'sd1);
    send_triangle(16'sd768, 16'sd1024, 16'sd1280);
    send_triangle(16'sd256, 16'sd256, 16'sd256);
    send_triangle(-16'sd1, 16'sd256, 16'sd256);
    send_triangle(16'sd256, -16'sd1, 16'sd256);
    send_triangle(16'sd256, 16'sd256, -16'sd1);
    send_triangle(16'sh8000, 16'sh8000, 16'sh8000);
    send_triangle(16'sd32767, 16'sd32767, 16'sh8000);
    send_triangle(16'sd0, 16'sd0, 16'sd0);
    send_triangle(16'sd0, 16'sd256, 16'sd256);
    send_triangle(16'sd256, 16'sd512, 16'sd768);
    send_triangle(16'sd768, 16'sd256, 16'sd512);
    send_triangle(16'sd512, 16'sd768, 16'sd256);
    send_triangle(16'sd256, 16'sd512, 16'sd767);
    send_triangle(16'sd100, 16'sd200, 16'sd299);
    send_triangle(16'sd1, 16'sd1, 16'sd32767);
    send_triangle(16'sd32767, 16'sd32767, 16'sd1);
    send_triangle(16'sd32767, 16'sd1, 16'sd32767);
    send_triangle(16'sd32767, 16'sd32766, 16'sd1);
  endtask

  // Random traffic with idle cycles on both sides.
  task automatic test_random_idle();
    send_random(290);
  endtask

  // A long stretch with the sender and receiver both at full rate.
  task automatic test_full_rate();
    gaps_on = 1'b0;
    send_random(150);
    gaps_on = 1'b1;
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall input.
  task automatic test_output_stall();
    hold_req = 300;
    send_random(60);
  endtask

  // The sender pauses until the pipeline is empty, then resumes.
  task automatic test_drain_pause();
    send_random(15);
    wait_results_drained();
    send_random(15);
  endtask

  // Receiver: random back-pressure, or a counted hold-off when one is asked for.
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (gaps_on) begin
      m_axis_tready <= ($urandom_range(99) >= 36);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result with the oldest expectation.
  always @(posedge clk_i) begin
    heron_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_areas.size() == 0) begin
        $error("Result with no request outstanding: tuser %b tdata %h",
               m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        want = pending_areas.pop_front();
        n_checked++;
        if (want.ok) n_good++;
        if (m_axis_tuser !== want.ok) begin
          $error("valid_res: expected %0d, got %0d", want.ok, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[PerimW-1:0] !== want.perim) begin
          $error("perimeter: expected %0d, got %0d", want.perim,
                 m_axis_tdata[PerimW-1:0]);
          errors++;
        end
        if (m_axis_tdata[PerimW +: AreaW] !== want.area) begin
          $error("area: expected %0d, got %0d", want.area,
                 m_axis_tdata[PerimW +: AreaW]);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_idle();
    test_full_rate();
    test_output_stall();
    test_drain_pause();

    wait_results_drained();
    repeat (SettleCycles) @(negedge clk_i);
    if (pending_areas.size() != 0) errors++;

    $display("Sent %0d triangles, checked %0d results (%0d valid, %0d rejected)",
             n_sent, n_checked, n_good, n_checked - n_good);
    $display("Covered extremes, random idling, full rate, output stall and drain");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
